[hdl/ccsg_pkg.sv]
// Package for the contour cell segment generator.
// Holds the fixed-point constants, register and edge codes, and the
// controller/datapath command and status structs. No dependencies.
package ccsg_pkg;

  localparam int FRAC_BITS = 16;               // fraction bits of a coordinate
  localparam int COORD_W   = 28;               // coordinate width, Q12.16
  localparam int INT_W     = COORD_W - FRAC_BITS;
  localparam int CORNER_W  = 33;               // corner after nudging
  localparam int DIFF_W    = CORNER_W + 1;     // corner difference
  localparam int ROW_W     = 12;
  localparam logic [ROW_W-1:0] ROW_SAT = 12'd4095;
  localparam int MAX_RESULTS = 32;
  localparam int NRES_W      = 6;

  // configuration register indexes
  localparam logic [2:0] REG_GRID_COLUMNS = 3'd0;
  localparam logic [2:0] REG_LEVEL_COUNT  = 3'd1;
  localparam logic [2:0] REG_CHECK_RANGE  = 3'd2;
  localparam logic [2:0] REG_VALID_MIN    = 3'd3;
  localparam logic [2:0] REG_VALID_MAX    = 3'd4;

  // cell edge codes
  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_RIGHT  = 2'd1;
  localparam logic [1:0] EDGE_BOTTOM = 2'd2;
  localparam logic [1:0] EDGE_LEFT   = 2'd3;

  typedef logic signed [CORNER_W-1:0] corner_t;

  typedef struct packed {
    logic load_pos;   // take a sample, issue row store read
    logic tbl_wr;     // write a level table entry
    logic fetch;      // form the cell corners, update row store
    logic lvl_rd;     // read the current level
    logic lvl_next;   // step to the next level
    logic nudge;      // raise corners equal to the level
    logic classify;   // build the crossing list
    logic div_start;  // start the fraction divide for the current point
    logic pt_store;   // store the finished point
    logic seg_make;   // hand a finished segment on
    logic flush;      // release the held segment as the final word
  } cmd_t;

  typedef struct packed {
    logic cell_ok;
    logic lvl_more;
    logic pt_more;
    logic pt_odd;
    logic div_done;
    logic out_free;
    logic pend_valid;
  } status_t;

endpackage

[hdl/ccsg_div.sv]
// Restoring divider for the edge fraction, one quotient bit a cycle.
// Needs num < den; depends on ccsg_pkg.
module ccsg_div import ccsg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIFF_W-1:0]   num,
  input  logic [DIFF_W-1:0]   den,
  output logic [FRAC_BITS-1:0] quo,
  output logic                done
);

  localparam int CNT_W = $clog2(FRAC_BITS);

  logic [DIFF_W-1:0]  rem;
  logic [DIFF_W-1:0]  dsr;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [DIFF_W:0]    shifted;

  assign shifted = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsr <= den;
      quo <= '0;
    end else if (busy) begin
      if (shifted >= {1'b0, dsr}) begin
        rem <= DIFF_W'(shifted - {1'b0, dsr});
        quo <= {quo[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[DIFF_W-1:0];
        quo <= {quo[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

[hdl/ccsg_dp.sv]
// Datapath: configuration, row store, level table, corner registers,
// crossing list, fraction divider and output word. Depends on ccsg_pkg, ccsg_div.
module ccsg_dp import ccsg_pkg::*; #(
  parameter int MAX_COLUMNS = 4096,
  parameter int NUM_LEVELS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic signed [31:0]   sample,
  input  logic                 start_frame,
  input  logic [3:0]           table_slot,
  input  logic signed [31:0]   level_value,
  input  cmd_t                 cmd,
  output status_t              st,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [3:0]           level_index,
  output logic [COORD_W-1:0]   start_x,
  output logic [COORD_W-1:0]   start_y,
  output logic [COORD_W-1:0]   end_x,
  output logic [COORD_W-1:0]   end_y,
  output logic                 last
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int LIW = $clog2(NUM_LEVELS + 1);

  // configuration
  logic [12:0]        grid_columns;
  logic [4:0]         level_count;
  logic               check_range;
  logic signed [31:0] valid_min;
  logic signed [31:0] valid_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= 13'd4096;
      level_count  <= 5'd1;
      check_range  <= 1'b0;
      valid_min    <= 32'sh8000_0000;
      valid_max    <= 32'sh7fff_ffff;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_COLUMNS: grid_columns <= cfg_data[12:0];
        REG_LEVEL_COUNT:  level_count  <= cfg_data[4:0];
        REG_CHECK_RANGE:  check_range  <= cfg_data[0];
        REG_VALID_MIN:    valid_min    <= cfg_data;
        REG_VALID_MAX:    valid_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CW:0]     cols;
  logic [LIW-1:0]  total;

  always_comb begin
    if (grid_columns < 13'd2)
      cols = (CW+1)'(2);
    else if (32'(grid_columns) > MAX_COLUMNS)
      cols = (CW+1)'(MAX_COLUMNS);
    else
      cols = (CW+1)'(grid_columns);
    if (32'(level_count) > NUM_LEVELS)
      total = LIW'(NUM_LEVELS);
    else
      total = LIW'(level_count);
  end

  // raster position
  logic [CW-1:0]    col_cnt, cc0, cc1, pos_c;
  logic [ROW_W-1:0] row_cnt, rc0, rc1, pos_r;
  logic [CW:0]      c_inc;
  logic signed [31:0] samp;
  logic [31:0]      rs_rd;
  logic [31:0]      row_mem [MAX_COLUMNS];

  always_comb begin
    cc0 = start_frame ? '0 : col_cnt;
    rc0 = start_frame ? '0 : row_cnt;
    cc1 = cc0;
    rc1 = rc0;
    if ({1'b0, cc0} >= cols) begin
      cc1 = '0;
      rc1 = (rc0 == ROW_SAT) ? rc0 : rc0 + 1'b1;
    end
  end

  assign c_inc = {1'b0, pos_c} + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load_pos) rs_rd <= row_mem[cc1];
    if (cmd.fetch)    row_mem[pos_c] <= samp;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pos) begin
      pos_c <= cc1;
      pos_r <= rc1;
      samp  <= sample;
    end
  end

  logic signed [31:0] left_s, upper_left_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt      <= '0;
      row_cnt      <= '0;
      left_s       <= '0;
      upper_left_s <= '0;
    end else if (cmd.fetch) begin
      upper_left_s <= rs_rd;
      left_s       <= samp;
      if (c_inc >= cols) begin
        col_cnt <= '0;
        row_cnt <= (pos_r == ROW_SAT) ? pos_r : pos_r + 1'b1;
      end else begin
        col_cnt <= c_inc[CW-1:0];
        row_cnt <= pos_r;
      end
    end
  end

  // range check on the raw corners
  logic               out_rng;
  logic signed [31:0] raw [4];

  always_comb begin
    raw[0] = upper_left_s;
    raw[1] = rs_rd;
    raw[2] = left_s;
    raw[3] = samp;
    out_rng = 1'b0;
    for (int i = 0; i < 4; i++)
      if (raw[i] < valid_min || raw[i] > valid_max) out_rng = 1'b1;
  end

  assign st.cell_ok = (pos_r != '0) && (pos_c != '0) && !(check_range && out_rng) &&
                      (total != '0);

  // level table
  logic [31:0]    lvl_mem [NUM_LEVELS];
  logic [31:0]    slot32;
  logic [31:0]    q_rd;
  logic [LIW-1:0] li;
  logic [31:0]    li32;
  corner_t        q;

  assign slot32 = 32'(table_slot);
  assign li32   = 32'(li);
  assign q      = {q_rd[31], q_rd};

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && slot32 < NUM_LEVELS) lvl_mem[slot32[LW-1:0]] <= level_value;
    if (cmd.lvl_rd) q_rd <= lvl_mem[li[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch)         li <= '0;
    else if (cmd.lvl_next) li <= li + 1'b1;
  end

  assign st.lvl_more = (li32 + 32'd1) < 32'(total);

  // corners: upper-left, upper-right, lower-left, lower-right
  corner_t k [4];

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      k[0] <= {upper_left_s[31], upper_left_s};
      k[1] <= {rs_rd[31], rs_rd};
      k[2] <= {left_s[31], left_s};
      k[3] <= {samp[31], samp};
    end else if (cmd.nudge) begin
      for (int i = 0; i < 4; i++)
        if (k[i] == q) k[i] <= k[i] + 1'b1;
    end
  end

  // crossing list
  logic [1:0]  ord [4];
  logic [1:0]  ord_n [4];
  logic [2:0]  np, np_n;
  logic [2:0]  pi;
  logic        saddle, neg, pick_a;
  logic [3:0]  crs;
  logic signed [CORNER_W+2:0] diff;

  function automatic logic betw(corner_t qq, corner_t a, corner_t b);
    return (qq < a && qq > b) || (qq > a && qq < b);
  endfunction

  always_comb begin
    saddle = (q < k[0] && q > k[1] && q > k[2] && q < k[3]) ||
             (q > k[0] && q < k[1] && q < k[2] && q > k[3]);
    diff = (CORNER_W+3)'(k[0]) + (CORNER_W+3)'(k[1]) + (CORNER_W+3)'(k[2]) +
           (CORNER_W+3)'(k[3]) - ((CORNER_W+3)'(q) <<< 2);
    neg = (diff == '0) ? (q < 0) : (diff < 0);
    pick_a = (neg && q > k[0]) || (!neg && q < k[0]);
    crs[0] = betw(q, k[0], k[1]);
    crs[1] = betw(q, k[1], k[3]);
    crs[2] = betw(q, k[2], k[3]);
    crs[3] = betw(q, k[0], k[2]);
    for (int i = 0; i < 4; i++) ord_n[i] = EDGE_TOP;
    np_n = '0;
    if (saddle) begin
      np_n = 3'd4;
      if (pick_a) begin
        ord_n[0] = EDGE_TOP;  ord_n[1] = EDGE_RIGHT;
        ord_n[2] = EDGE_LEFT; ord_n[3] = EDGE_BOTTOM;
      end else begin
        ord_n[0] = EDGE_LEFT;   ord_n[1] = EDGE_TOP;
        ord_n[2] = EDGE_BOTTOM; ord_n[3] = EDGE_RIGHT;
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (crs[i]) begin
          ord_n[np_n[1:0]] = 2'(i);
          np_n = np_n + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      ord <= ord_n;
      np  <= np_n;
      pi  <= '0;
    end else if (cmd.pt_store) begin
      pi <= pi + 1'b1;
    end
  end

  assign st.pt_more = pi < np;
  assign st.pt_odd  = pi[0];

  // divide set-up
  logic [1:0]           edge_c, edge_q;
  corner_t              ea, eb;
  logic signed [DIFF_W-1:0] dn, dd;
  logic [DIFF_W-1:0]    num_m, den_m;
  logic [FRAC_BITS-1:0] quo;
  logic                 div_done;

  always_comb begin
    edge_c = ord[pi[1:0]];
    case (edge_c)
      EDGE_TOP:    begin ea = k[0]; eb = k[1]; end
      EDGE_RIGHT:  begin ea = k[3]; eb = k[1]; end
      EDGE_BOTTOM: begin ea = k[2]; eb = k[3]; end
      default:     begin ea = k[2]; eb = k[0]; end
    endcase
    dn = DIFF_W'(q) - DIFF_W'(ea);
    dd = DIFF_W'(eb) - DIFF_W'(ea);
    num_m = dn[DIFF_W-1] ? DIFF_W'(-dn) : DIFF_W'(dn);
    den_m = dd[DIFF_W-1] ? DIFF_W'(-dd) : DIFF_W'(dd);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) edge_q <= edge_c;
  end

  ccsg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num_m),
    .den   (den_m),
    .quo   (quo),
    .done  (div_done)
  );

  assign st.div_done = div_done;

  // point position
  logic [31:0]        c32;
  logic [INT_W-1:0]   xl_i, xr_i, yu_i, yd_i;
  logic [COORD_W-1:0] pt_x, pt_y, yd_f;
  logic [COORD_W-1:0] px [2];
  logic [COORD_W-1:0] py [2];

  always_comb begin
    c32  = 32'(pos_c);
    xr_i = c32[INT_W-1:0];
    xl_i = xr_i - 1'b1;
    yd_i = pos_r[INT_W-1:0];
    yu_i = yd_i - 1'b1;
    yd_f = {yd_i, {FRAC_BITS{1'b0}}} - COORD_W'(quo);
    case (edge_q)
      EDGE_TOP:    begin pt_x = {xl_i, quo}; pt_y = {yu_i, {FRAC_BITS{1'b0}}}; end
      EDGE_RIGHT:  begin pt_x = {xr_i, {FRAC_BITS{1'b0}}}; pt_y = yd_f; end
      EDGE_BOTTOM: begin pt_x = {xl_i, quo}; pt_y = {yd_i, {FRAC_BITS{1'b0}}}; end
      default:     begin pt_x = {xl_i, {FRAC_BITS{1'b0}}}; pt_y = yd_f; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_store) begin
      px[pi[0]] <= pt_x;
      py[pi[0]] <= pt_y;
    end
  end

  // held segment and output word
  logic [3:0]         pend_lvl;
  logic [COORD_W-1:0] pend_sx, pend_sy, pend_ex, pend_ey;
  logic               pend_valid;
  logic [NRES_W-1:0]  nres;
  logic               take_seg, emit;

  assign st.out_free   = !out_valid || out_ready;
  assign st.pend_valid = pend_valid;
  assign take_seg = cmd.seg_make && (nres < NRES_W'(MAX_RESULTS));
  assign emit     = (take_seg && pend_valid) || (cmd.flush && pend_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      nres       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.fetch) nres <= '0;
      else if (take_seg) nres <= nres + 1'b1;
      if (take_seg) pend_valid <= 1'b1;
      else if (cmd.flush) pend_valid <= 1'b0;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      level_index <= pend_lvl;
      start_x     <= pend_sx;
      start_y     <= pend_sy;
      end_x       <= pend_ex;
      end_y       <= pend_ey;
      last        <= cmd.flush;
    end
    if (take_seg) begin
      pend_lvl <= li32[3:0];
      pend_sx  <= px[0];
      pend_sy  <= py[0];
      pend_ex  <= px[1];
      pend_ey  <= py[1];
    end
  end

endmodule

[hdl/ccsg_ctrl.sv]
// Controller state machine: sequences position, levels, points and
// segment release. Depends on ccsg_pkg.
module ccsg_ctrl import ccsg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    kind,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FETCH  = 4'd1;
  localparam logic [3:0] S_LRD    = 4'd2;
  localparam logic [3:0] S_NUDGE  = 4'd3;
  localparam logic [3:0] S_CLASS  = 4'd4;
  localparam logic [3:0] S_PSTART = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_SEG    = 4'd7;
  localparam logic [3:0] S_NEXT   = 4'd8;
  localparam logic [3:0] S_FLUSH  = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (kind) begin
            cmd.tbl_wr = 1'b1;
          end else begin
            cmd.load_pos = 1'b1;
            state_next   = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = st.cell_ok ? S_LRD : S_IDLE;
      end
      S_LRD: begin
        cmd.lvl_rd = 1'b1;
        state_next = S_NUDGE;
      end
      S_NUDGE: begin
        cmd.nudge  = 1'b1;
        state_next = S_CLASS;
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_next   = S_PSTART;
      end
      S_PSTART: begin
        if (st.pt_more) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.pt_store = 1'b1;
          state_next   = st.pt_odd ? S_SEG : S_PSTART;
        end
      end
      S_SEG: begin
        if (!st.pend_valid || st.out_free) begin
          cmd.seg_make = 1'b1;
          state_next   = S_PSTART;
        end
      end
      S_NEXT: begin
        if (st.lvl_more) begin
          cmd.lvl_next = 1'b1;
          state_next   = S_LRD;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/contour_cell_segment_generator.sv]
// Marching-squares contour cell segment generator, top level.
// Table write word is taken in the idle state. Sample word: accept, then fetch; a completed
// cell then steps through level read, nudge and classify per level, a 16-bit restoring
// divide per edge crossing, a hand-on per segment and a release of the final segment, plus any output stall.
// Words are taken one at a time; output register decouples the result side.
// Reset (rst, synchronous): control, position and previous-sample registers cleared;
// corner registers, row store and level table contents are not cleared.
module contour_cell_segment_generator import ccsg_pkg::*; #(
  parameter int MAX_COLUMNS = 4096,
  parameter int NUM_LEVELS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic signed [31:0]  sample,
  input  logic                start_frame,
  input  logic [3:0]          table_slot,
  input  logic signed [31:0]  level_value,
  // segment words
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          level_index,
  output logic [COORD_W-1:0]  start_x,
  output logic [COORD_W-1:0]  start_y,
  output logic [COORD_W-1:0]  end_x,
  output logic [COORD_W-1:0]  end_y,
  output logic                last
);

  cmd_t    cmd;
  status_t st;

  // The controller walks levels and crossings; the datapath holds all data.
  ccsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ccsg_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .NUM_LEVELS  (NUM_LEVELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (sample),
    .start_frame (start_frame),
    .table_slot  (table_slot),
    .level_value (level_value),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .level_index (level_index),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .last        (last)
  );

endmodule

[hdl/ccsg_checker.sv]
// Port-level checks for the contour cell segment generator, and the bind
// that attaches them. Depends on contour_cell_segment_generator.
module ccsg_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] level_index,
  input logic [27:0] start_x,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(start_x) && $stable(last) && $stable(level_index))
    else $error("output word changed while stalled");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !kind |=> !in_ready)
    else $error("sample word did not occupy the block");

  a_table_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind |=> in_ready)
    else $error("table write did not complete in one cycle");

endmodule

bind contour_cell_segment_generator ccsg_checker u_ccsg_checker (.*);

[tb/sv/tb_contour_cell_segment_generator.sv]
// Testbench for the marching-squares contour cell segment generator.
// Self-checking: an in-bench predictor follows every accepted word; depends
// on ccsg_pkg and the contour_cell_segment_generator RTL only.
module tb_contour_cell_segment_generator import ccsg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // one input word as the bench keeps it
  typedef struct {
    bit          kind;
    logic [31:0] smp;
    bit          sf;
    logic [3:0]  slot;
    logic [31:0] lvl;
  } word_t;

  // one segment word
  typedef struct {
    logic [3:0]         li;
    logic [COORD_W-1:0] sx, sy, ex, ey;
    bit                 lst;
  } seg_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = 1'b0;
  logic signed [31:0] sample = '0;
  logic               start_frame = 1'b0;
  logic [3:0]         table_slot = '0;
  logic signed [31:0] level_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         level_index;
  logic [COORD_W-1:0] start_x, start_y, end_x, end_y;
  logic               last;

  contour_cell_segment_generator uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .sample(sample),
    .start_frame(start_frame), .table_slot(table_slot), .level_value(level_value),
    .out_valid(out_valid), .out_ready(out_ready), .level_index(level_index),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y), .last(last)
  );

  initial forever #5 clk = ~clk;

  // overall time limit, far above the slowest legal run
  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  word_t pending_words[$];   // words waiting for the driver
  seg_t  segs_due[$];        // predicted segments not yet seen
  int    errors = 0;
  int    segs_seen = 0;
  bit    no_idle = 1'b0;     // phase with no idling on either side

  // ---------------------------------------------------------------------------
  // Contour predictor: mirror of registers and block state
  // ---------------------------------------------------------------------------
  logic [12:0] m_cols = 13'd4096;
  logic [4:0]  m_nlev = 5'd1;
  bit          m_chk  = 1'b0;
  longint      m_vmin = -64'sd2147483648;
  longint      m_vmax = 64'sd2147483647;
  longint      m_row_mem [4096];
  longint      m_levels [16];
  longint      m_left = 0, m_upleft = 0;
  int unsigned m_col = 0, m_row = 0;

  // interpolated fraction of q between a and b, Q0.FRAC_BITS, truncated
  function automatic longint cross_frac(longint q, longint a, longint b);
    longint nm, dm, r;
    nm = (q - a < 0) ? a - q : q - a;
    dm = (b - a < 0) ? a - b : b - a;
    if (dm == 0) return 0;
    r = (nm << FRAC_BITS) / dm;
    return (r >= (64'sd1 << FRAC_BITS)) ? (64'sd1 << FRAC_BITS) - 1 : r;
  endfunction

  // crossing point on one edge of the cell ending at row r, column c
  task automatic edge_point(input logic [1:0] e, input longint q, input longint k[4],
                            input int unsigned r, input int unsigned c,
                            output longint x, output longint y);
    longint xl, xr, yu, yd;
    xl = longint'(c - 1) << FRAC_BITS;
    xr = longint'(c) << FRAC_BITS;
    yu = longint'(r - 1) << FRAC_BITS;
    yd = longint'(r) << FRAC_BITS;
    case (e)
      EDGE_TOP:    begin x = xl + cross_frac(q, k[0], k[1]); y = yu; end
      EDGE_RIGHT:  begin x = xr; y = yd - cross_frac(q, k[3], k[1]); end
      EDGE_BOTTOM: begin x = xl + cross_frac(q, k[2], k[3]); y = yd; end
      default:     begin x = xl; y = yd - cross_frac(q, k[2], k[0]); end
    endcase
  endtask

  function automatic bit strictly_between(longint q, longint a, longint b);
    return (q < a && q > b) || (q > a && q < b);
  endfunction

  // segments of one completed cell; k = UL, UR, LL, LR
  task automatic cell_segments(input longint k_in[4], input int unsigned r,
                               input int unsigned c);
    longint      k[4], q, sum4, px[4], py[4];
    logic [1:0]  ord[4];
    int          np, nl;
    seg_t        s, cell_out[$];
    k = k_in;
    if (m_chk)
      for (int i = 0; i < 4; i++)
        if (k[i] < m_vmin || k[i] > m_vmax) return;
    nl = (m_nlev > 16) ? 16 : m_nlev;
    for (int li = 0; li < nl; li++) begin
      q = m_levels[li];
      // corners sitting on the level move up one LSB, and stay moved
      for (int i = 0; i < 4; i++) if (k[i] == q) k[i] = k[i] + 1;
      if ((q > k[0] && q > k[1] && q > k[2] && q > k[3]) ||
          (q < k[0] && q < k[1] && q < k[2] && q < k[3])) continue;
      np = 0;
      if ((q < k[0] && q > k[1] && q > k[2] && q < k[3]) ||
          (q > k[0] && q < k[1] && q < k[2] && q > k[3])) begin
        // saddle: decide by the cell mean against the level
        sum4 = k[0] + k[1] + k[2] + k[3] - 4 * q;
        if (sum4 == 0) sum4 = (q >= 0) ? 1 : -1;
        if ((sum4 < 0 && q > k[0]) || (sum4 > 0 && q < k[0])) begin
          ord[0] = EDGE_TOP; ord[1] = EDGE_RIGHT; ord[2] = EDGE_LEFT; ord[3] = EDGE_BOTTOM;
        end else begin
          ord[0] = EDGE_LEFT; ord[1] = EDGE_TOP; ord[2] = EDGE_BOTTOM; ord[3] = EDGE_RIGHT;
        end
        np = 4;
      end else begin
        if (strictly_between(q, k[0], k[1])) begin ord[np] = EDGE_TOP;    np++; end
        if (strictly_between(q, k[1], k[3])) begin ord[np] = EDGE_RIGHT;  np++; end
        if (strictly_between(q, k[2], k[3])) begin ord[np] = EDGE_BOTTOM; np++; end
        if (strictly_between(q, k[0], k[2])) begin ord[np] = EDGE_LEFT;   np++; end
      end
      for (int i = 0; i < np; i++) edge_point(ord[i], q, k, r, c, px[i], py[i]);
      for (int i = 0; i + 1 < np; i += 2) begin
        s.li = li[3:0];
        s.sx = px[i][COORD_W-1:0];
        s.sy = py[i][COORD_W-1:0];
        s.ex = px[i+1][COORD_W-1:0];
        s.ey = py[i+1][COORD_W-1:0];
        s.lst = 1'b0;
        cell_out = {cell_out, s};
      end
    end
    if (cell_out.size() > 0) cell_out[cell_out.size()-1].lst = 1'b1;
    segs_due = {segs_due, cell_out};
  endtask

  // predictor step for one accepted word
  task automatic track_word(input word_t w);
    int unsigned cols, r, c;
    longint      s, k[4];
    if (w.kind) begin
      m_levels[w.slot] = longint'(signed'(w.lvl));
      return;
    end
    s = longint'(signed'(w.smp));
    if (w.sf) begin m_col = 0; m_row = 0; end
    cols = (m_cols < 2) ? 2 : ((m_cols > 4096) ? 4096 : m_cols);
    if (m_col >= cols) begin
      m_col = 0;
      if (m_row < 4095) m_row++;
    end
    r = m_row;
    c = m_col;
    k[0] = m_upleft; k[1] = m_row_mem[c]; k[2] = m_left; k[3] = s;
    m_upleft = m_row_mem[c];
    m_row_mem[c] = s;
    m_left = s;
    m_col = c + 1;
    if (m_col >= cols) begin
      m_col = 0;
      if (m_row < 4095) m_row++;
    end
    if (r >= 1 && c >= 1) cell_segments(k, r, c);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued words, random gap after each
  // ---------------------------------------------------------------------------
  word_t  cur_word;
  int     send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) track_word(cur_word);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          kind        <= cur_word.kind;
          sample      <= cur_word.smp;
          start_frame <= cur_word.sf;
          table_slot  <= cur_word.slot;
          level_value <= cur_word.lvl;
          in_valid    <= 1'b1;
          send_gap = no_idle ? 0 : $urandom_range(0, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor / receiver: checks segments, random stalls, one long hold-off
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  int recv_stall = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  seg_t due;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        segs_seen++;
        if (segs_due.size() == 0) begin
          $error("segment word with none expected");
          errors++;
        end else begin
          due = segs_due.pop_front();
          check_field("level_index", due.li, level_index);
          check_field("start_x", due.sx, start_x);
          check_field("start_y", due.sy, start_y);
          check_field("end_x", due.ex, end_x);
          check_field("end_y", due.ey, end_y);
          check_field("last", due.lst, last);
        end
        recv_stall = no_idle ? 0 : $urandom_range(0, 18);
      end
      // long hold-off while plenty of words are queued: block must back up
      if (!held_once && segs_seen >= 40 && pending_words.size() > 15) begin
        held_once = 1'b1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  longint gen_levels [16];   // levels as the generator last queued them

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      REG_GRID_COLUMNS: m_cols = val[12:0];
      REG_LEVEL_COUNT:  m_nlev = val[4:0];
      REG_CHECK_RANGE:  m_chk  = val[0];
      REG_VALID_MIN:    m_vmin = longint'(signed'(val));
      REG_VALID_MAX:    m_vmax = longint'(signed'(val));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_level(input int slot, input logic [31:0] v);
    word_t w;
    w = '{kind: 1'b1, smp: $urandom, sf: 1'b0, slot: slot[3:0], lvl: v};
    gen_levels[slot] = longint'(signed'(v));
    pending_words = {pending_words, w};
  endtask

  task automatic push_sample(input logic [31:0] v, input bit sf);
    word_t w;
    w = '{kind: 1'b0, smp: v, sf: sf, slot: 4'($urandom), lvl: $urandom};
    pending_words = {pending_words, w};
  endtask

  // elevation drawn mostly close to a level so cells get crossed
  function automatic logic [31:0] pick_elev();
    int     p;
    longint base;
    p = $urandom_range(0, 99);
    base = gen_levels[$urandom_range(0, 15)];
    if (p < 60) return 32'(base + longint'($urandom_range(0, 4000)) - 2000);
    if (p < 72) return 32'(base);
    if (p < 88) return $urandom;
    if (p < 94) return 32'h7FFF_FFFF;
    return 32'h8000_0000;
  endfunction

  // block is idle: sender drained, every segment in, then one cell's worth
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (segs_due.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  logic [31:0] col_set [8] = '{32'd2, 32'd3, 32'd0, 32'd5, 32'd8191, 32'd4, 32'd1, 32'd7};
  logic [31:0] lev_set [8] = '{32'd16, 32'd4, 32'd0, 32'd31, 32'd1, 32'd16, 32'd8, 32'd2};

  initial begin
    int eff_cols, n_words;
    logic [31:0] lo, hi;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: whole level table, extremes, a saddle with mean on the level,
    // corners equal to a level
    cfg_write(REG_GRID_COLUMNS, 32'd2);
    push_level(0, 32'd0);
    push_level(1, 32'h7FFF_FFFF);
    push_level(2, 32'h8000_0000);
    push_level(3, 32'hFFFF_FFFF);
    for (int i = 4; i < 16; i++) push_level(i, 32'(int'($urandom_range(0, 6000)) - 3000));
    push_sample(32'd5, 1'b1);  push_sample(-32'sd5, 1'b0);
    push_sample(-32'sd5, 1'b0); push_sample(32'd5, 1'b0);
    push_sample(32'd0, 1'b0);  push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h8000_0000, 1'b0); push_sample(-32'sd3, 1'b0);
    wait_idle();

    // random phases, registers changed between them only
    for (int ph = 0; ph < 9; ph++) begin
      cfg_write(REG_GRID_COLUMNS, (ph < 8) ? col_set[ph] : 32'($urandom_range(2, 9)));
      cfg_write(REG_LEVEL_COUNT, (ph < 8) ? lev_set[ph] : 32'($urandom_range(1, 16)));
      cfg_write(REG_CHECK_RANGE, 32'(ph % 2));
      case (ph % 3)
        0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
        1: begin lo = 32'(-1500); hi = 32'd1500; end
        default: begin lo = $urandom; hi = $urandom; end
      endcase
      cfg_write(REG_VALID_MIN, lo);
      cfg_write(REG_VALID_MAX, hi);
      no_idle = (ph % 4 == 3);

      // refresh a few levels; full random values now and then
      for (int i = 0; i < 4; i++)
        push_level($urandom_range(0, 15), ($urandom_range(0, 4) == 0) ? $urandom :
                   32'(int'($urandom_range(0, 6000)) - 3000));

      eff_cols = (m_cols < 2) ? 2 : ((m_cols > 4096) ? 4096 : m_cols);
      n_words = (eff_cols > 64) ? 6 : 26;   // wide raster: a partial row only
      for (int i = 0; i < n_words; i++) begin
        // occasional table write or restarted frame as noise
        if ($urandom_range(0, 19) == 0)
          push_level($urandom_range(0, 15), 32'(int'($urandom_range(0, 6000)) - 3000));
        push_sample(pick_elev(), (i == 0) || ($urandom_range(0, 29) == 0));
      end
      wait_idle();
    end

    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
